>>> rtl/msf_pkg.sv
package msf_pkg;

   // Default frame limits
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   // Fixed field widths
   localparam int ENERGY_W  = 12;
   localparam int COST_W    = 21;
   localparam int SEAM_W    = 9;
   localparam int CSR_W     = 10;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_W-1:0]  CSR_DIM_RESET = 10'd512;
   localparam logic [COST_W-1:0] COST_MAX      = '1;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_NOT_READY = 1'b1
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST
   } seq_state_type;

   typedef struct packed {
      op_type              op;
      logic [ENERGY_W-1:0] energy;
   } cmd_type;

   typedef struct packed {
      logic [CSR_W-1:0] width;
      logic [CSR_W-1:0] height;
   } frame_cfg_type;

endpackage

>>> rtl/msf_if.sv
// Request channel: one load or fetch per transfer
interface msf_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [msf_pkg::ENERGY_W-1:0]  energy_value;

   modport source (output valid, output req_type, output energy_value, input ready);
   modport sink   (input valid, input req_type, input energy_value, output ready);
endinterface

// Response channel: one seam entry or status per transfer
interface msf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [msf_pkg::SEAM_W-1:0]  seam_row;
   logic [msf_pkg::SEAM_W-1:0]  seam_col;
   logic                        seam_last;
   logic                        status;

   modport source (output valid, output seam_row, output seam_col, output seam_last,
                   output status, input ready);
   modport sink   (input valid, input seam_row, input seam_col, input seam_last,
                   input status, output ready);
endinterface

>>> rtl/min_vertical_seam_finder.sv
// Vertical seam finder for seam carving. Send a frame of energy values in row-major
// order as load transfers (req_type 0); each stored cost is the energy plus the
// smallest of the up to three costs above it, saturating at 21 bits, and the
// leftmost minimum of the bottom row is tracked on the fly. Frame width and height
// are taken from the CSRs at the first load of each frame. Fetch transfers
// (req_type 1) then return the seam one row per response, bottom row first, with
// seam_last set on row 0; a fetch before the frame is complete or past the top row
// answers with status 1 and zero fields. A load after a completed frame starts the
// next one. Requests go through a two-entry queue into a sequencer that owns the
// cost memory (one write port, one registered read port): a row-0 load is stored
// straight from the idle state; a load of a later row or a later fetch first reads
// the N (1 to 3) neighbor columns above it, one per cycle through the memory's read
// port; the first fetch of a seam and a fetch answered with status 1 are answered
// straight from the idle state. A fetch waits while the response register still
// holds an untaken response. The cost memory needs no clearing after reset.
module min_vertical_seam_finder #(
   parameter int MAX_WIDTH  = msf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = msf_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   msf_req_if.sink                         req_if,
   msf_rsp_if.source                       rsp_if,
   input  logic                            csr_wr_en,
   input  logic [msf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msf_pkg::CSR_W-1:0]       csr_wr_data
);

   msf_pkg::frame_cfg_type cfg_ff, cfg_in;
   msf_pkg::cmd_type       cmd;
   logic                   cmd_valid;
   logic                   cmd_pop;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (msf_pkg::csr_index_type'(csr_index))
            msf_pkg::CSR_FRAME_WIDTH:  cfg_in.width  = csr_wr_data;
            msf_pkg::CSR_FRAME_HEIGHT: cfg_in.height = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= msf_pkg::CSR_DIM_RESET;
         cfg_ff.height <= msf_pkg::CSR_DIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request intake and queue
   msf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Cost computation and seam trace
   msf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_if    (rsp_if)
   );

endmodule

>>> rtl/msf_ram.sv
module msf_ram #(
   parameter int WIDTH = msf_pkg::COST_W,
   parameter int DEPTH = msf_pkg::MAX_WIDTH_DEF * msf_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/msf_front.sv
module msf_front (
   input  logic             clock,
   input  logic             reset,
   msf_req_if.sink          req_if,
   output logic             cmd_valid,
   output msf_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   localparam int QDEPTH = msf_pkg::QDEPTH;
   localparam int QPW    = msf_pkg::QPW;
   localparam int QCW    = msf_pkg::QCW;

   msf_pkg::cmd_type q_ff [QDEPTH];
   msf_pkg::cmd_type push_cmd;
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             push;

   // Classify the request into a queued command
   assign push_cmd.op     = msf_pkg::op_type'(req_if.req_type);
   assign push_cmd.energy = req_if.energy_value;

   assign req_if.ready = (count_ff != QCW'(QDEPTH));
   assign push         = req_if.valid & req_if.ready;

   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/msf_back.sv
module msf_back #(
   parameter int MAX_WIDTH  = msf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = msf_pkg::MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  msf_pkg::frame_cfg_type cfg,
   input  logic                   cmd_valid,
   input  msf_pkg::cmd_type       cmd,
   output logic                   cmd_pop,
   msf_rsp_if.source              rsp_if
);

   localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DWW    = $clog2(MAX_WIDTH + 1);
   localparam int DHW    = $clog2(MAX_HEIGHT + 1);
   localparam int CSR_W  = msf_pkg::CSR_W;
   localparam int CMPW_W = (DWW > CSR_W) ? DWW : CSR_W;
   localparam int CMPW_H = (DHW > CSR_W) ? DHW : CSR_W;
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COST_W = msf_pkg::COST_W;
   localparam int SUMW   = COST_W + 1;
   localparam int ENW    = msf_pkg::ENERGY_W;
   localparam int SW     = msf_pkg::SEAM_W;

   // Sequencer and frame state
   msf_pkg::seq_state_type state_ff, state_in;
   logic [RW-1:0]     load_row_ff, load_row_in;
   logic [CW-1:0]     load_col_ff, load_col_in;
   logic              load_done_ff, load_done_in;
   logic [COST_W-1:0] bmin_cost_ff, bmin_cost_in;
   logic [CW-1:0]     bmin_col_ff, bmin_col_in;
   logic [DHW-1:0]    fetch_row_ff, fetch_row_in;
   logic [CW-1:0]     last_col_ff, last_col_in;
   logic [DWW-1:0]    frm_w_ff, frm_w_in;
   logic [DHW-1:0]    frm_h_ff, frm_h_in;

   // Current neighbor scan
   msf_pkg::op_type   op_ff, op_in;
   logic [ENW-1:0]    energy_ff, energy_in;
   logic [RW-1:0]     scan_row_ff, scan_row_in;
   logic [CW-1:0]     scan_col_ff, scan_col_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic              pend_ff, pend_in;
   logic              first_ff, first_in;
   logic [CW-1:0]     pend_col_ff, pend_col_in;
   logic [COST_W-1:0] best_cost_ff, best_cost_in;
   logic [CW-1:0]     best_col_ff, best_col_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]          rsp_row_ff, rsp_row_in;
   logic [SW-1:0]          rsp_col_ff, rsp_col_in;
   logic                   rsp_last_ff, rsp_last_in;
   msf_pkg::status_type    rsp_status_ff, rsp_status_in;

   // Combinational helpers
   logic [DWW-1:0]    cfg_w, eff_w;
   logic [DHW-1:0]    cfg_h, eff_h;
   logic              first_px;
   logic              fetch_ok;
   logic              out_free;
   logic [CW-1:0]     center, win_lo, win_hi;
   logic              take;
   logic [COST_W-1:0] min_cost, sat_cost, load_cost;
   logic [CW-1:0]     min_col;
   logic [SUMW-1:0]   cost_sum;
   logic              commit_load;
   logic              fill;
   logic [RW-1:0]     fill_row;
   logic [CW-1:0]     fill_col;
   logic              fill_last;
   msf_pkg::status_type fill_status;

   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [COST_W-1:0] ram_wr_data, ram_rd_data;

   // Cost store: one row-major entry per pixel
   msf_ram #(
      .WIDTH (COST_W),
      .DEPTH (DEPTH)
   ) u_cost_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_addr = AW'(scan_row_ff) * AW'(MAX_WIDTH) + AW'(scan_col_ff);
   assign ram_wr_addr = AW'(load_row_ff) * AW'(MAX_WIDTH) + AW'(load_col_ff);

   // Frame size from the registers, 0 acts as 1 and oversize clips to the maximum
   always_comb begin
      if (cfg.width == '0) begin
         cfg_w = DWW'(1);
      end else if (CMPW_W'(cfg.width) > CMPW_W'(MAX_WIDTH)) begin
         cfg_w = DWW'(MAX_WIDTH);
      end else begin
         cfg_w = DWW'(cfg.width);
      end
      if (cfg.height == '0) begin
         cfg_h = DHW'(1);
      end else if (CMPW_H'(cfg.height) > CMPW_H'(MAX_HEIGHT)) begin
         cfg_h = DHW'(MAX_HEIGHT);
      end else begin
         cfg_h = DHW'(cfg.height);
      end
   end

   // First pixel of a frame latches the size
   assign first_px = (load_row_ff == '0) && (load_col_ff == '0);
   assign eff_w    = first_px ? cfg_w : frm_w_ff;
   assign eff_h    = first_px ? cfg_h : frm_h_ff;

   assign fetch_ok = load_done_ff && (fetch_row_ff < frm_h_ff);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Three-column window around the center, clipped at the frame edges
   assign center = (cmd.op == msf_pkg::OP_LOAD) ? load_col_ff : last_col_ff;
   assign win_lo = (center != '0) ? center - 1'b1 : '0;
   assign win_hi = ((DWW'(center) + DWW'(1)) < frm_w_ff) ? center + 1'b1
                                                         : CW'(frm_w_ff - DWW'(1));

   // Leftmost minimum: a later column wins only if strictly smaller
   assign take     = first_ff || (ram_rd_data < best_cost_ff);
   assign min_cost = take ? ram_rd_data : best_cost_ff;
   assign min_col  = take ? pend_col_ff : best_col_ff;

   // Saturating cost add
   assign cost_sum = {1'b0, min_cost} + SUMW'(energy_ff);
   assign sat_cost = cost_sum[COST_W] ? msf_pkg::COST_MAX : cost_sum[COST_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msf_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == msf_pkg::OP_LOAD) begin
                  if (load_row_ff != '0) begin
                     state_in = msf_pkg::ST_SCAN;
                  end
               end else if (out_free && fetch_ok && (fetch_row_ff != '0)) begin
                  state_in = msf_pkg::ST_SCAN;
               end
            end
         end
         msf_pkg::ST_SCAN: begin
            if (scan_col_ff == hi_ff) begin
               state_in = msf_pkg::ST_LAST;
            end
         end
         msf_pkg::ST_LAST: begin
            state_in = msf_pkg::ST_IDLE;
         end
         default: begin
            state_in = msf_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      load_done_in  = load_done_ff;
      bmin_cost_in  = bmin_cost_ff;
      bmin_col_in   = bmin_col_ff;
      fetch_row_in  = fetch_row_ff;
      last_col_in   = last_col_ff;
      frm_w_in      = frm_w_ff;
      frm_h_in      = frm_h_ff;
      op_in         = op_ff;
      energy_in     = energy_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      hi_in         = hi_ff;
      pend_in       = pend_ff;
      first_in      = first_ff;
      pend_col_in   = pend_col_ff;
      best_cost_in  = best_cost_ff;
      best_col_in   = best_col_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      cmd_pop       = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_data   = '0;
      commit_load   = 1'b0;
      load_cost     = '0;
      fill          = 1'b0;
      fill_row      = '0;
      fill_col      = '0;
      fill_last     = 1'b0;
      fill_status   = msf_pkg::STATUS_OK;

      case (state_ff)
         msf_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == msf_pkg::OP_LOAD) begin
                  cmd_pop = 1'b1;
                  // A load after completion opens a new frame
                  if (load_done_ff) begin
                     load_done_in = 1'b0;
                     bmin_cost_in = msf_pkg::COST_MAX;
                     bmin_col_in  = '0;
                     fetch_row_in = '0;
                     last_col_in  = '0;
                  end
                  if (first_px) begin
                     frm_w_in = cfg_w;
                     frm_h_in = cfg_h;
                  end
                  if (load_row_ff == '0) begin
                     commit_load = 1'b1;
                     load_cost   = COST_W'(cmd.energy);
                  end else begin
                     op_in       = msf_pkg::OP_LOAD;
                     energy_in   = cmd.energy;
                     scan_row_in = load_row_ff - 1'b1;
                     scan_col_in = win_lo;
                     hi_in       = win_hi;
                     pend_in     = 1'b0;
                     first_in    = 1'b1;
                  end
               end else if (out_free) begin
                  cmd_pop = 1'b1;
                  if (!fetch_ok) begin
                     fill        = 1'b1;
                     fill_status = msf_pkg::STATUS_NOT_READY;
                  end else if (fetch_row_ff == '0) begin
                     // Bottom row comes straight from the tracked minimum
                     fill         = 1'b1;
                     fill_row     = RW'(frm_h_ff - DHW'(1));
                     fill_col     = bmin_col_ff;
                     fill_last    = (frm_h_ff == DHW'(1));
                     last_col_in  = bmin_col_ff;
                     fetch_row_in = fetch_row_ff + 1'b1;
                  end else begin
                     op_in       = msf_pkg::OP_FETCH;
                     scan_row_in = RW'(frm_h_ff - DHW'(1) - fetch_row_ff);
                     scan_col_in = win_lo;
                     hi_in       = win_hi;
                     pend_in     = 1'b0;
                     first_in    = 1'b1;
                  end
               end
            end
         end
         msf_pkg::ST_SCAN: begin
            // Issue one read per cycle, compare the one that returns
            ram_rd_en   = 1'b1;
            pend_in     = 1'b1;
            pend_col_in = scan_col_ff;
            if (pend_ff) begin
               best_cost_in = min_cost;
               best_col_in  = min_col;
               first_in     = 1'b0;
            end
            if (scan_col_ff != hi_ff) begin
               scan_col_in = scan_col_ff + 1'b1;
            end
         end
         msf_pkg::ST_LAST: begin
            if (op_ff == msf_pkg::OP_LOAD) begin
               commit_load = 1'b1;
               load_cost   = sat_cost;
            end else begin
               fill         = 1'b1;
               fill_row     = scan_row_ff;
               fill_col     = min_col;
               fill_last    = (scan_row_ff == '0);
               last_col_in  = min_col;
               fetch_row_in = fetch_row_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Store a cost, track the bottom-row minimum, step the load position
      if (commit_load) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = load_cost;
         if ((DHW'(load_row_ff) == eff_h - DHW'(1)) &&
             ((load_col_ff == '0) || (load_cost < bmin_cost_ff))) begin
            bmin_cost_in = load_cost;
            bmin_col_in  = load_col_ff;
         end
         if ((DWW'(load_col_ff) + DWW'(1)) >= eff_w) begin
            load_col_in = '0;
            if ((DHW'(load_row_ff) + DHW'(1)) >= eff_h) begin
               load_row_in  = '0;
               load_done_in = 1'b1;
            end else begin
               load_row_in = load_row_ff + 1'b1;
            end
         end else begin
            load_col_in = load_col_ff + 1'b1;
         end
      end

      // Response register: fill or drain
      if (fill) begin
         rsp_valid_in  = 1'b1;
         rsp_row_in    = SW'(fill_row);
         rsp_col_in    = SW'(fill_col);
         rsp_last_in   = fill_last;
         rsp_status_in = fill_status;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msf_pkg::ST_IDLE;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         load_done_ff <= 1'b0;
         bmin_cost_ff <= msf_pkg::COST_MAX;
         bmin_col_ff  <= '0;
         fetch_row_ff <= '0;
         last_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         load_done_ff <= load_done_in;
         bmin_cost_ff <= bmin_cost_in;
         bmin_col_ff  <= bmin_col_in;
         fetch_row_ff <= fetch_row_in;
         last_col_ff  <= last_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      frm_w_ff      <= frm_w_in;
      frm_h_ff      <= frm_h_in;
      op_ff         <= op_in;
      energy_ff     <= energy_in;
      scan_row_ff   <= scan_row_in;
      scan_col_ff   <= scan_col_in;
      hi_ff         <= hi_in;
      pend_ff       <= pend_in;
      first_ff      <= first_in;
      pend_col_ff   <= pend_col_in;
      best_cost_ff  <= best_cost_in;
      best_col_ff   <= best_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.seam_row  = rsp_row_ff;
   assign rsp_if.seam_col  = rsp_col_ff;
   assign rsp_if.seam_last = rsp_last_ff;
   assign rsp_if.status    = rsp_status_ff;

endmodule
